@@ rtl/core/mics_pkg.sv @@
// package for the multinomial inverse-cdf sampler
// shared constants, request kinds, error codes and controller command/status types
`default_nettype none
package mics_pkg;
   localparam int MaxColumns = 256;
   localparam int WeightBits = 16;
   localparam int RandomBits = 23;
   localparam int IdxBits = $clog2(MaxColumns);
   localparam int CntBits = IdxBits + 1;
   localparam int SumBits = WeightBits + IdxBits;
   localparam int DrawBits = 13;

   localparam logic [1:0] KIND_START = 2'd0;
   localparam logic [1:0] KIND_APPEND = 2'd1;
   localparam logic [1:0] KIND_DRAW = 2'd2;
   localparam logic [1:0] KIND_IGNORED = 2'd3;

   localparam logic [1:0] ERR_OK = 2'd0;
   localparam logic [1:0] ERR_ZERO_SUM = 2'd1;
   localparam logic [1:0] ERR_EXHAUSTED = 2'd2;
   localparam logic [1:0] ERR_OVERFLOW = 2'd3;

   localparam logic CSR_WITH_REPL = 1'b0;
   localparam logic CSR_SAMPLES = 1'b1;

   typedef struct packed {
      logic load;
      logic start_scan;
      logic start_rebuild;
   } cmd_type;

   typedef struct packed {
      logic scan_busy;
      logic rebuild_busy;
      logic immediate;
   } stat_type;
endpackage
`default_nettype wire

@@ rtl/core/mics_ctrl.sv @@
// controller state machine for the sampler
// depends on mics_pkg
`default_nettype none
module mics_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [1:0]        req_kind,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   input  wire logic              with_repl,
   output mics_pkg::cmd_type      cmd,
   input  mics_pkg::stat_type     stat
);
   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001, ST_DECIDE = 6'b000010, ST_ISSUE = 6'b000100,
      ST_SCAN = 6'b001000, ST_REBUILD = 6'b010000, ST_OUT = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic req_acc;

   assign req_acc = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);

   always_comb begin
      cmd = '0;
      cmd.load = req_acc;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc && req_kind == mics_pkg::KIND_DRAW) state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            state_in = ST_ISSUE;
         end
         ST_ISSUE: begin
            if (stat.immediate) begin
               state_in = ST_OUT;
            end else begin
               cmd.start_scan = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (!stat.scan_busy) begin
               if (!with_repl) begin
                  cmd.start_rebuild = 1'b1;
                  state_in = ST_REBUILD;
               end else begin
                  state_in = ST_OUT;
               end
            end
         end
         ST_REBUILD: begin
            if (!stat.rebuild_busy) state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_stall) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end
endmodule
`default_nettype wire

@@ rtl/core/mics_dp.sv @@
// datapath: weight/prefix/zero-list memories, scan and rebuild counters
// depends on mics_pkg
`default_nettype none
module mics_dp (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic [1:0]                         req_kind,
   input  wire logic [mics_pkg::WeightBits-1:0]    req_weight,
   input  wire logic [mics_pkg::RandomBits-1:0]    req_random_fraction,
   input  wire logic [mics_pkg::DrawBits-1:0]      samples_per_row,
   input  mics_pkg::cmd_type                       cmd,
   output mics_pkg::stat_type                      stat,
   output logic [7:0]                              rsp_sample_index,
   output logic [1:0]                              rsp_error_code,
   output logic                                    rsp_last_of_row
);
   localparam int IB = mics_pkg::IdxBits;
   localparam int CB = mics_pkg::CntBits;
   localparam int SB = mics_pkg::SumBits;
   localparam int WB = mics_pkg::WeightBits;
   localparam int RB = mics_pkg::RandomBits;
   localparam int DB = mics_pkg::DrawBits;
   localparam int PB = SB + RB;

   logic [WB-1:0] wmem [mics_pkg::MaxColumns];
   logic [SB-1:0] pmem [mics_pkg::MaxColumns];
   logic [IB-1:0] zmem [mics_pkg::MaxColumns];

   logic [CB:0]   col_ff;
   logic [CB-1:0] zc_ff;
   logic [SB-1:0] tot_ff;
   logic [DB-1:0] dc_ff;
   logic [RB-1:0] u_ff;
   logic [PB-1:0] ut_ff;
   logic          draw_ff;
   logic          scan_ff, rb_ff, rbpend_ff;
   logic [CB:0]   k_ff;
   logic [IB-1:0] hit_ff;
   logic          found_ff;
   logic [WB-1:0] rw_ff;
   logic [SB-1:0] rp_ff;
   logic [IB-1:0] zr_ff;
   logic          rd_vld_ff;
   logic [IB-1:0] rd_k_ff;
   logic [SB-1:0] racc_ff;
   logic [7:0]    idx_ff;
   logic [1:0]    err_ff;
   logic          last_ff;
   logic          imm_ff;

   logic [DB-1:0] dnext;
   logic [CB:0]   nonzero;
   logic [DB:0]   jrel;
   logic          append_ok;
   logic [IB-1:0] rd_addr;

   assign nonzero = col_ff - {1'b0, zc_ff};
   assign jrel = {1'b0, dc_ff} - {{(DB+1-CB-1){1'b0}}, nonzero};
   assign dnext = dc_ff + 1'b1;
   assign stat.scan_busy = scan_ff;
   assign stat.rebuild_busy = rb_ff;
   assign stat.immediate = imm_ff;
   assign rsp_sample_index = idx_ff;
   assign rsp_error_code = err_ff;
   assign rsp_last_of_row = last_ff;

   always_comb begin
      if (cmd.load && req_kind == mics_pkg::KIND_START) append_ok = 1'b1;
      else append_ok = (col_ff < (CB+1)'(mics_pkg::MaxColumns));
   end

   assign rd_addr = k_ff[IB-1:0];

   // memory writes and reads
   always_ff @(posedge clock) begin
      logic [IB-1:0] wa;
      logic [SB-1:0] ns;
      wa = (req_kind == mics_pkg::KIND_START) ? '0 : col_ff[IB-1:0];
      ns = ((req_kind == mics_pkg::KIND_START) ? '0 : tot_ff) + SB'(req_weight);
      if (cmd.load && req_kind[1] == 1'b0 && append_ok) begin
         wmem[wa] <= req_weight;
         if (req_weight != '0) pmem[wa] <= ns;
         else zmem[(req_kind == mics_pkg::KIND_START) ? '0 : zc_ff[IB-1:0]] <= wa;
      end
      if (rd_vld_ff && rb_ff && rw_ff != '0) pmem[rd_k_ff] <= racc_ff + SB'(rw_ff);
      if (cmd.start_rebuild && found_ff) wmem[hit_ff] <= '0;
      rw_ff <= wmem[rd_addr];
      rp_ff <= pmem[rd_addr];
      zr_ff <= zmem[jrel[IB-1:0]];
   end

   always_ff @(posedge clock) begin
      logic [PB-1:0] lhs;
      if (reset) begin
         col_ff <= '0; zc_ff <= '0; tot_ff <= '0; dc_ff <= '0;
         scan_ff <= 1'b0; rb_ff <= 1'b0; rd_vld_ff <= 1'b0; imm_ff <= 1'b0;
         draw_ff <= 1'b0; found_ff <= 1'b0; rbpend_ff <= 1'b0;
      end else begin
         draw_ff <= cmd.load && req_kind == mics_pkg::KIND_DRAW;
         if (cmd.load) begin
            if (req_kind == mics_pkg::KIND_START) begin
               col_ff <= (CB+1)'(1);
               zc_ff <= (req_weight == '0) ? CB'(1) : '0;
               tot_ff <= SB'(req_weight);
               dc_ff <= '0;
            end else if (req_kind == mics_pkg::KIND_APPEND) begin
               if (append_ok) begin
                  col_ff <= col_ff + 1'b1;
                  if (req_weight == '0) zc_ff <= zc_ff + 1'b1;
                  tot_ff <= tot_ff + SB'(req_weight);
               end else begin
                  col_ff <= (CB+1)'(mics_pkg::MaxColumns + 1);
               end
            end else if (req_kind == mics_pkg::KIND_DRAW) begin
               u_ff <= req_random_fraction;
            end
         end
         // decide the draw class in the cycle after acceptance
         if (draw_ff) begin
            dc_ff <= dnext;
            last_ff <= (dnext == samples_per_row);
            idx_ff <= '0;
            ut_ff <= PB'(u_ff) * PB'(tot_ff);
            if (col_ff > (CB+1)'(mics_pkg::MaxColumns)) begin
               err_ff <= mics_pkg::ERR_OVERFLOW;
               imm_ff <= 1'b1;
            end else if (col_ff == {1'b0, zc_ff}) begin
               err_ff <= mics_pkg::ERR_ZERO_SUM;
               imm_ff <= 1'b1;
            end else if (tot_ff != '0) begin
               err_ff <= mics_pkg::ERR_OK;
               imm_ff <= 1'b0;
            end else if (!(dc_ff >= DB'(nonzero)) || !(jrel < (DB+1)'(zc_ff))) begin
               err_ff <= mics_pkg::ERR_EXHAUSTED;
               imm_ff <= 1'b1;
            end else begin
               err_ff <= mics_pkg::ERR_OK;
               imm_ff <= 1'b1;
               rbpend_ff <= 1'b1;
            end
         end else begin
            imm_ff <= 1'b0;
         end
         if (rbpend_ff) begin
            rbpend_ff <= 1'b0;
         end
         if (imm_ff && rbpend_ff) idx_ff <= 8'(zr_ff);
         // scan
         if (cmd.start_scan) begin
            scan_ff <= 1'b1; k_ff <= '0; rd_vld_ff <= 1'b0; found_ff <= 1'b0;
         end else if (scan_ff) begin
            if (k_ff < col_ff) k_ff <= k_ff + 1'b1;
            rd_vld_ff <= (k_ff < col_ff);
            rd_k_ff <= rd_addr;
            lhs = {rp_ff, {RB{1'b0}}};
            if (rd_vld_ff && rw_ff != '0 && lhs >= ut_ff) begin
               scan_ff <= 1'b0;
               found_ff <= 1'b1;
               hit_ff <= rd_k_ff;
               idx_ff <= 8'(rd_k_ff);
            end else if (!rd_vld_ff && k_ff >= col_ff && k_ff != '0) begin
               scan_ff <= 1'b0;
               hit_ff <= '0;
               found_ff <= 1'b1;
            end
         end
         // rebuild
         if (cmd.start_rebuild) begin
            rb_ff <= 1'b1; k_ff <= '0; rd_vld_ff <= 1'b0; racc_ff <= '0;
         end else if (rb_ff) begin
            if (k_ff < col_ff) k_ff <= k_ff + 1'b1;
            rd_vld_ff <= (k_ff < col_ff);
            rd_k_ff <= rd_addr;
            if (rd_vld_ff && rw_ff != '0) racc_ff <= racc_ff + SB'(rw_ff);
            if (!rd_vld_ff && k_ff >= col_ff) begin
               rb_ff <= 1'b0;
               tot_ff <= racc_ff;
            end
         end
      end
   end
endmodule
`default_nettype wire

@@ rtl/core/multinomial_inverse_cdf_sampler.sv @@
// top level of the multinomial inverse-cdf sampler
// request channel loads weights or draws; response channel returns one result per draw
// requests use valid/stall; csr port is valid/ready, register 0 with_replacement,
// register 1 samples_per_row. weight requests (kinds 0, 1) give no response. a draw
// response needs no scan (errors, zero columns); otherwise it is valid after a scan
// through the prefix memory read port, and, without replacement, after the rebuild
// pass that follows the scan. one request is worked on at a time; the next request
// can be taken in the cycle after the response is taken.
// the result waits in an output register while rsp_stall is high; req_stall stays
// high until it is taken. reset (synchronous) clears counts, totals and the
// controller; the memories are not cleared, only written entries are read.
// csr writes are accepted every cycle and should be made while idle.
`default_nettype none
module multinomial_inverse_cdf_sampler (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_kind,
   input  wire logic [15:0] req_weight,
   input  wire logic [22:0] req_random_fraction,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_sample_index,
   output logic [1:0]       rsp_error_code,
   output logic             rsp_last_of_row,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic        csr_index,
   input  wire logic [12:0] csr_data
);
   mics_pkg::cmd_type  cmd;
   mics_pkg::stat_type stat;
   logic        repl_ff;
   logic [12:0] spr_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         repl_ff <= 1'b1;
         spr_ff <= 13'd1;
      end else if (csr_valid) begin
         if (csr_index == mics_pkg::CSR_WITH_REPL) repl_ff <= csr_data[0];
         else spr_ff <= csr_data;
      end
   end

   mics_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .req_kind(req_kind), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .with_repl(repl_ff), .cmd(cmd), .stat(stat)
   );

   mics_dp u_dp (
      .clock(clock), .reset(reset), .req_kind(req_kind), .req_weight(req_weight),
      .req_random_fraction(req_random_fraction), .samples_per_row(spr_ff),
      .cmd(cmd), .stat(stat), .rsp_sample_index(rsp_sample_index),
      .rsp_error_code(rsp_error_code), .rsp_last_of_row(rsp_last_of_row)
   );
endmodule
`default_nettype wire
